// ===== hw/rtl/kdp_rain_rate_assert.svh =====
// ----------------------------------------------------------------------------
// kdp_rain_rate assertion macros
// Shared property forms for the rain rate checker, clocked on clock and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef KDP_RAIN_RATE_ASSERT_SVH
`define KDP_RAIN_RATE_ASSERT_SVH

// same-cycle implication
`define KDP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KDP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/kdp_pkg.sv =====
// ----------------------------------------------------------------------------
// kdp_pkg
// Types, register codes and constants of the Kdp rain rate pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package kdp_pkg;

   localparam int LOG_STEPS = 16;
   localparam int EXP_STEPS = 16;

   localparam logic [1:0] CSR_CORR_THRESHOLD  = 2'd0;
   localparam logic [1:0] CSR_MIN_USAGE_RATE  = 2'd1;
   localparam logic [1:0] CSR_RATE_MULTIPLIER = 2'd2;
   localparam logic [1:0] CSR_RATE_EXPONENT   = 2'd3;

   localparam logic [14:0] CORR_THRESHOLD_RESET  = 15'd14746;
   localparam logic [15:0] MIN_USAGE_RATE_RESET  = 16'd160;
   localparam logic [15:0] RATE_MULTIPLIER_RESET = 16'd11264;
   localparam logic [14:0] RATE_EXPONENT_RESET   = 15'd13468;

   typedef struct packed {
      logic [14:0] corr_threshold;
      logic [15:0] min_usage_rate;
      logic [15:0] rate_multiplier;
      logic [14:0] rate_exponent;
   } cfg_type;

   // per-bin decision bits that ride along with the arithmetic
   typedef struct packed {
      logic        fallback;
      logic        neg;
      logic        kzero;
      logic [15:0] reflect_rate;
   } side_type;

   // 2^(2^-step) in Q1.30, by repeated floor square roots from 2.0
   function automatic logic [30:0] exp2_factor(input int unsigned step);
      logic [63:0] t;
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      t = 64'd1 << 31;
      for (int unsigned s = 1; s <= step; s++) begin
         v = t << 30;
         r = 64'd0;
         b = 64'd1 << 62;
         for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         t = r;
      end
      return t[30:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/kdp_ifs.sv =====
// ----------------------------------------------------------------------------
// kdp channel interfaces
// Valid/ready channels for bin words in and rate words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface kdp_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] phase_slope;
   logic        phase_valid;
   logic        attenuated;
   logic [14:0] correlation;
   logic [15:0] reflect_rate;

   modport source (output valid, phase_slope, phase_valid, attenuated, correlation,
                   reflect_rate, input ready);
   modport sink (input valid, phase_slope, phase_valid, attenuated, correlation,
                 reflect_rate, output ready);
endinterface

interface kdp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] rain_rate;
   logic        used_phase;

   modport source (output valid, rain_rate, used_phase, input ready);
   modport sink (input valid, rain_rate, used_phase, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/kdp_log2_pipe.sv =====
// ----------------------------------------------------------------------------
// kdp_log2_pipe
// Qualifies a bin and forms log2 of |Kdp| in Q.16, one squaring per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module kdp_log2_pipe (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire kdp_pkg::cfg_type  cfg,
   input  wire logic              in_valid,
   input  wire logic [15:0]       in_phase_slope,
   input  wire logic              in_phase_valid,
   input  wire logic              in_attenuated,
   input  wire logic [14:0]       in_correlation,
   input  wire logic [15:0]       in_reflect_rate,
   output logic                   out_valid,
   output kdp_pkg::side_type      out_side,
   output logic signed [20:0]     out_log
);

   logic              valid_ff [0:kdp_pkg::LOG_STEPS];
   kdp_pkg::side_type side_ff  [0:kdp_pkg::LOG_STEPS];
   logic [3:0]        n_ff     [0:kdp_pkg::LOG_STEPS];
   logic [15:0]       f_ff     [0:kdp_pkg::LOG_STEPS];
   logic [15:0]       frac_ff  [0:kdp_pkg::LOG_STEPS];

   logic [15:0]       f_in     [1:kdp_pkg::LOG_STEPS];
   logic [15:0]       frac_in  [1:kdp_pkg::LOG_STEPS];

   kdp_pkg::side_type side_in;
   logic [3:0]        n_in;
   logic [15:0]       f0_in;
   logic [15:0]       k_ext;

   // entry: top bit search and mantissa
   always_comb begin
      k_ext = {1'b0, in_phase_slope[14:0]};
      n_in  = 4'd0;
      for (int i = 0; i < 15; i++) begin
         if (k_ext[i]) begin
            n_in = 4'(i);
         end
      end
      f0_in = 16'(k_ext << (4'd15 - n_in));
      side_in.fallback = !in_phase_valid ||
                         (!in_attenuated &&
                          ((in_correlation < cfg.corr_threshold) ||
                           (in_reflect_rate < cfg.min_usage_rate)));
      side_in.neg          = in_phase_slope[15];
      side_in.kzero        = (in_phase_slope == 16'd0);
      side_in.reflect_rate = in_reflect_rate;
   end

   // squaring steps: one fraction bit each
   always_comb begin
      logic [31:0] sq;
      for (int s = 1; s <= kdp_pkg::LOG_STEPS; s++) begin
         sq = f_ff[s-1] * f_ff[s-1];
         if (sq[31]) begin
            f_in[s]    = sq[31:16];
            frac_in[s] = {frac_ff[s-1][14:0], 1'b1};
         end else begin
            f_in[s]    = sq[30:15];
            frac_in[s] = {frac_ff[s-1][14:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= kdp_pkg::LOG_STEPS; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s <= kdp_pkg::LOG_STEPS; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         n_ff[0]    <= n_in;
         f_ff[0]    <= f0_in;
         frac_ff[0] <= 16'd0;
         for (int s = 1; s <= kdp_pkg::LOG_STEPS; s++) begin
            side_ff[s] <= side_ff[s-1];
            n_ff[s]    <= n_ff[s-1];
            f_ff[s]    <= f_in[s];
            frac_ff[s] <= frac_in[s];
         end
      end
   end

   assign out_valid = valid_ff[kdp_pkg::LOG_STEPS];
   assign out_side  = side_ff[kdp_pkg::LOG_STEPS];
   assign out_log   = $signed({5'({1'b0, n_ff[kdp_pkg::LOG_STEPS]} - 5'd8),
                               frac_ff[kdp_pkg::LOG_STEPS]});

endmodule

`default_nettype wire

// ===== hw/rtl/kdp_exp2_pipe.sv =====
// ----------------------------------------------------------------------------
// kdp_exp2_pipe
// Scales the log by the exponent and forms 2^frac in Q1.30, one factor per
// stage.
// ----------------------------------------------------------------------------
`default_nettype none

module kdp_exp2_pipe (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire kdp_pkg::cfg_type  cfg,
   input  wire logic              in_valid,
   input  wire kdp_pkg::side_type in_side,
   input  wire logic signed [20:0] in_log,
   output logic                   out_valid,
   output kdp_pkg::side_type      out_side,
   output logic [5:0]             out_ipb,
   output logic [30:0]            out_pow
);

   localparam logic [36:0] ROUND_BIAS = (37'd1 << 35) + (37'd1 << 13);
   localparam logic [30:0] ONE_Q30    = 31'd1 << 30;

   logic              valid_p_ff;
   kdp_pkg::side_type side_p_ff;
   logic signed [35:0] y_ff;
   logic signed [35:0] y_in;
   logic [36:0]       u_in;

   logic              valid_ff [0:kdp_pkg::EXP_STEPS];
   kdp_pkg::side_type side_ff  [0:kdp_pkg::EXP_STEPS];
   logic [5:0]        ipb_ff   [0:kdp_pkg::EXP_STEPS];
   logic [15:0]       g_ff     [0:kdp_pkg::EXP_STEPS];
   logic [30:0]       r_ff     [0:kdp_pkg::EXP_STEPS];
   logic [30:0]       r_in     [1:kdp_pkg::EXP_STEPS];

   assign y_in = 36'(in_log) * 36'($signed({1'b0, cfg.rate_exponent}));
   // bias keeps the sum positive, then round half up to Q.16
   assign u_in = 37'(y_ff) + ROUND_BIAS;

   for (genvar j = 1; j <= kdp_pkg::EXP_STEPS; j++) begin : g_step
      localparam logic [30:0] FACTOR = kdp_pkg::exp2_factor(j);
      logic [61:0] mul;
      logic [61:0] rnd;
      assign mul = r_ff[j-1] * FACTOR;
      assign rnd = mul + (62'd1 << 29);
      assign r_in[j] = g_ff[j-1][kdp_pkg::EXP_STEPS-j] ? rnd[60:30] : r_ff[j-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_p_ff <= 1'b0;
         for (int s = 0; s <= kdp_pkg::EXP_STEPS; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         valid_p_ff  <= in_valid;
         valid_ff[0] <= valid_p_ff;
         for (int s = 1; s <= kdp_pkg::EXP_STEPS; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_p_ff  <= in_side;
         y_ff       <= y_in;
         side_ff[0] <= side_p_ff;
         ipb_ff[0]  <= u_in[35:30];
         g_ff[0]    <= u_in[29:14];
         r_ff[0]    <= ONE_Q30;
         for (int s = 1; s <= kdp_pkg::EXP_STEPS; s++) begin
            side_ff[s] <= side_ff[s-1];
            ipb_ff[s]  <= ipb_ff[s-1];
            g_ff[s]    <= g_ff[s-1];
            r_ff[s]    <= r_in[s];
         end
      end
   end

   assign out_valid = valid_ff[kdp_pkg::EXP_STEPS];
   assign out_side  = side_ff[kdp_pkg::EXP_STEPS];
   assign out_ipb   = ipb_ff[kdp_pkg::EXP_STEPS];
   assign out_pow   = r_ff[kdp_pkg::EXP_STEPS];

endmodule

`default_nettype wire

// ===== hw/rtl/kdp_scale.sv =====
// ----------------------------------------------------------------------------
// kdp_scale
// Multiplies by the coefficient, rounds, saturates and picks the final rate.
// ----------------------------------------------------------------------------
`default_nettype none

module kdp_scale (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire kdp_pkg::cfg_type  cfg,
   input  wire logic              in_valid,
   input  wire kdp_pkg::side_type in_side,
   input  wire logic [5:0]        in_ipb,
   input  wire logic [30:0]       in_pow,
   output logic                   out_valid,
   output logic [15:0]            out_rain_rate,
   output logic                   out_used_phase
);

   logic              valid_a_ff;
   logic              valid_b_ff;
   logic              valid_c_ff;
   kdp_pkg::side_type side_a_ff;
   kdp_pkg::side_type side_b_ff;
   logic [46:0]       prod_ff;
   logic [6:0]        shift_a_ff;
   logic [6:0]        shift_b_ff;
   logic [47:0]       rnd_ff;
   logic [15:0]       rate_ff;
   logic              used_ff;

   logic [6:0]        shift_in;
   logic [47:0]       rnd_in;
   logic [47:0]       scaled;
   logic [16:0]       zero_rate;
   logic [15:0]       rate_in;
   logic              used_in;

   // shift = 34 - ip, with ip carried as ip + 32
   assign shift_in = 7'd66 - {1'b0, in_ipb};
   assign rnd_in   = {1'b0, prod_ff} + ((48'd1 << shift_a_ff) >> 1);
   assign scaled   = rnd_ff >> shift_b_ff;
   assign zero_rate = ({1'b0, cfg.rate_multiplier} + 17'd8) >> 4;

   always_comb begin
      rate_in = side_b_ff.reflect_rate;
      used_in = 1'b0;
      if (side_b_ff.fallback) begin
         rate_in = side_b_ff.reflect_rate;
         used_in = 1'b0;
      end else if (side_b_ff.neg) begin
         // negative Kdp falls back to the reflectivity rate unless the coefficient is zero
         if (cfg.rate_multiplier == 16'd0) begin
            rate_in = 16'd0;
            used_in = 1'b1;
         end
      end else if (side_b_ff.kzero) begin
         rate_in = (cfg.rate_exponent == 15'd0) ? zero_rate[15:0] : 16'd0;
         used_in = 1'b1;
      end else begin
         rate_in = (scaled[47:16] != 32'd0) ? 16'hFFFF : scaled[15:0];
         used_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_a_ff  <= in_side;
         prod_ff    <= in_pow * cfg.rate_multiplier;
         shift_a_ff <= shift_in;
         side_b_ff  <= side_a_ff;
         rnd_ff     <= rnd_in;
         shift_b_ff <= shift_a_ff;
         rate_ff    <= rate_in;
         used_ff    <= used_in;
      end
   end

   assign out_valid      = valid_c_ff;
   assign out_rain_rate  = rate_ff;
   assign out_used_phase = used_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/kdp_rain_rate.sv =====
// ----------------------------------------------------------------------------
// kdp_rain_rate
// Polarimetric rain rate from Kdp by a power law, with reflectivity fallback.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one range bin per word: Kdp, its valid flag, the
//   attenuated flag, correlation and the reflectivity rate. rsp_chan returns
//   one word per bin, in order: the chosen rain rate and whether Kdp was used.
//   csr_write/csr_index/csr_data set the four registers; write them only
//   while no bin is in flight.
//   From accepted bin to rsp valid a word passes one qualify stage,
//   sixteen log2 squaring stages, two exponent product stages, sixteen exp2
//   factor stages and three scale stages, the last being the output register.
//   Throughput is one bin per cycle unless rsp_chan stalls; each stage
//   takes a new word each cycle, the deepest ones one 16 or 31 bit multiply.
//   Reset clears all valid bits and loads the register defaults; no bins are
//   lost or invented. When rsp_chan stalls with a word waiting, the whole
//   pipeline holds, empty slots included, and req_chan.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module kdp_rain_rate (
   input  wire logic        clock,
   input  wire logic        reset,
   kdp_req_if.sink          req_chan,
   kdp_rsp_if.source        rsp_chan,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   kdp_pkg::cfg_type  cfg_ff;
   logic              advance;

   logic              log_valid;
   kdp_pkg::side_type log_side;
   logic signed [20:0] log_val;

   logic              exp_valid;
   kdp_pkg::side_type exp_side;
   logic [5:0]        exp_ipb;
   logic [30:0]       exp_pow;

   logic              out_valid;
   logic [15:0]       out_rate;
   logic              out_used;

   // hold everything while a finished word waits
   assign advance        = !out_valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.corr_threshold  <= kdp_pkg::CORR_THRESHOLD_RESET;
         cfg_ff.min_usage_rate  <= kdp_pkg::MIN_USAGE_RATE_RESET;
         cfg_ff.rate_multiplier <= kdp_pkg::RATE_MULTIPLIER_RESET;
         cfg_ff.rate_exponent   <= kdp_pkg::RATE_EXPONENT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            kdp_pkg::CSR_CORR_THRESHOLD:  cfg_ff.corr_threshold  <= csr_data[14:0];
            kdp_pkg::CSR_MIN_USAGE_RATE:  cfg_ff.min_usage_rate  <= csr_data;
            kdp_pkg::CSR_RATE_MULTIPLIER: cfg_ff.rate_multiplier <= csr_data;
            kdp_pkg::CSR_RATE_EXPONENT:   cfg_ff.rate_exponent   <= csr_data[14:0];
            default: begin
            end
         endcase
      end
   end

   kdp_log2_pipe u_log2 (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .cfg             (cfg_ff),
      .in_valid        (req_chan.valid),
      .in_phase_slope  (req_chan.phase_slope),
      .in_phase_valid  (req_chan.phase_valid),
      .in_attenuated   (req_chan.attenuated),
      .in_correlation  (req_chan.correlation),
      .in_reflect_rate (req_chan.reflect_rate),
      .out_valid       (log_valid),
      .out_side        (log_side),
      .out_log         (log_val)
   );

   kdp_exp2_pipe u_exp2 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .in_valid  (log_valid),
      .in_side   (log_side),
      .in_log    (log_val),
      .out_valid (exp_valid),
      .out_side  (exp_side),
      .out_ipb   (exp_ipb),
      .out_pow   (exp_pow)
   );

   kdp_scale u_scale (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .cfg            (cfg_ff),
      .in_valid       (exp_valid),
      .in_side        (exp_side),
      .in_ipb         (exp_ipb),
      .in_pow         (exp_pow),
      .out_valid      (out_valid),
      .out_rain_rate  (out_rate),
      .out_used_phase (out_used)
   );

   assign rsp_chan.valid      = out_valid;
   assign rsp_chan.rain_rate  = out_rate;
   assign rsp_chan.used_phase = out_used;

endmodule

`default_nettype wire

// ===== hw/rtl/kdp_rain_rate_check.sv =====
// ----------------------------------------------------------------------------
// kdp_rain_rate_check
// Port-level checks on the rain rate block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kdp_rain_rate_assert.svh"

module kdp_rain_rate_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_rain_rate,
   input wire logic        rsp_used_phase
);

   `KDP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp word dropped while stalled")
   `KDP_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_rain_rate) && $stable(rsp_used_phase), "rsp word changed while stalled")
   `KDP_ASSERT_IMPLY(a_flow, rsp_ready || !rsp_valid, req_ready, "input held while output is free")
   `KDP_ASSERT_IMPLY(a_reset_empty, $past(reset), !rsp_valid, "rsp word right after reset")

endmodule

bind kdp_rain_rate kdp_rain_rate_check u_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_rain_rate  (rsp_chan.rain_rate),
   .rsp_used_phase (rsp_chan.used_phase)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: rain rate selection bench
// Drives range bins into kdp_rain_rate under changing register settings and
// random idling on both channels. Each rate word is checked against a local
// model of the Kdp power law and of the reflectivity fallback.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam int LATENCY     = 38;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BINS  = 245;

   typedef enum logic {ROW_BIN, ROW_CSR} row_kind_type;

   typedef struct {
      logic [15:0] slope;
      logic        pv;
      logic        att;
      logic [14:0] corr;
      logic [15:0] zr;
   } bin_type;

   typedef struct {
      logic [15:0] rate;
      logic        used;
   } rate_type;

   typedef struct {
      row_kind_type kind;
      bin_type      bin;
      logic [1:0]   idx;
      logic [15:0]  data;
      bit           typed;
      rate_type     want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   kdp_req_if req_bus ();
   kdp_rsp_if rsp_bus ();

   kdp_rain_rate u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   kdp_pkg::cfg_type regs;
   logic [63:0] exp_root [1:16];
   rate_type    rate_q [$];
   bit          typed_q [$];
   rate_type    typed_want;
   bit          typed_pending = 0;
   int          errors = 0;
   int          cycles = 0;
   int          bins_sent = 0;
   int          kdp_words = 0;
   int          fallback_words = 0;
   int          csr_writes = 0;
   int          snd_idle = 0;
   int          rcv_idle = 0;
   int          hold_left = 0;
   row_type     dir_rows [$];

   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // log2 of k in Q.16, less 8 for the 1/256 scale
   function automatic longint log_kdp(int unsigned k);
      int          n;
      logic [63:0] f;
      longint      frac;
      n = 15;
      frac = 0;
      while (n > 0 && k[n] == 1'b0) n--;
      f = (k << (15 - n)) & 64'hFFFF;
      for (int i = 0; i < 16; i++) begin
         f = (f * f) >> 15;
         frac = frac << 1;
         if (f >= 64'd65536) begin
            f = f >> 1;
            frac = frac | 1;
         end
      end
      return longint'(n - 8) * 65536 + frac;
   endfunction

   function automatic logic [15:0] power_rate(int unsigned k);
      logic [63:0] m;
      logic [63:0] r;
      logic [63:0] q;
      logic [63:0] prod;
      longint      y;
      int          ip;
      int          s;
      m = regs.rate_multiplier;
      if (k == 0) return (regs.rate_exponent == 0) ? 16'((m + 8) >> 4) : 16'd0;
      y = log_kdp(k) * longint'(regs.rate_exponent);
      q = (64'(y + (longint'(32) << 30)) + 64'd8192) >> 14;
      ip = int'(q >> 16) - 32;
      r = 64'd1 << 30;
      for (int j = 1; j <= 16; j++)
         if (q[16 - j]) r = (r * exp_root[j] + (64'd1 << 29)) >> 30;
      s = 34 - ip;
      prod = (m * r + (64'd1 << (s - 1))) >> s;
      return (prod > 64'd65535) ? 16'hFFFF : prod[15:0];
   endfunction

   function automatic rate_type choose_rate(bin_type b);
      rate_type    o;
      int unsigned mag;
      o.rate = b.zr;
      o.used = 1'b0;
      if (!b.pv) return o;
      if (!b.att && (b.corr < regs.corr_threshold || b.zr < regs.min_usage_rate)) return o;
      if (b.slope[15]) begin
         if (regs.rate_multiplier != 0) return o;
         o.rate = 16'd0;
         o.used = 1'b1;
         return o;
      end
      mag = b.slope;
      o.rate = power_rate(mag);
      o.used = 1'b1;
      return o;
   endfunction

   function automatic row_type bin_row(int slope, bit pv, bit att, int corr, int zr,
                                       bit typed, int rate, bit used);
      row_type w;
      w.kind = ROW_BIN;
      w.bin = '{16'(slope), pv, att, 15'(corr), 16'(zr)};
      w.idx = '0;
      w.data = '0;
      w.typed = typed;
      w.want = '{16'(rate), used};
      return w;
   endfunction

   function automatic row_type csr_row(logic [1:0] idx, int data);
      row_type w;
      w = bin_row(0, 0, 0, 0, 0, 0, 0, 0);
      w.kind = ROW_CSR;
      w.idx = idx;
      w.data = 16'(data);
      return w;
   endfunction

   function automatic bin_type random_bin();
      bin_type     b;
      int unsigned pick;
      pick = $urandom_range(9);
      b.slope = 16'($urandom);
      b.pv = $urandom_range(1);
      b.att = $urandom_range(1);
      b.corr = 15'($urandom);
      b.zr = 16'($urandom);
      if (pick >= 2) begin
         // well-formed bin that passes the fallback checks, now and then negated
         b.pv = 1'b1;
         b.att = ($urandom_range(3) == 0);
         b.corr = 15'(regs.corr_threshold + $urandom_range(32767 - regs.corr_threshold));
         b.zr = 16'(regs.min_usage_rate + $urandom_range(65535 - regs.min_usage_rate));
         case ($urandom_range(2))
            0: b.slope = 16'($urandom_range(255));
            1: b.slope = 16'($urandom_range(4095));
            default: b.slope = 16'($urandom_range(32767));
         endcase
         if ($urandom_range(4) == 0) b.slope = -b.slope;
      end
      return b;
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = data;
      case (idx)
         kdp_pkg::CSR_CORR_THRESHOLD:  regs.corr_threshold = data[14:0];
         kdp_pkg::CSR_MIN_USAGE_RATE:  regs.min_usage_rate = data;
         kdp_pkg::CSR_RATE_MULTIPLIER: regs.rate_multiplier = data;
         kdp_pkg::CSR_RATE_EXPONENT:   regs.rate_exponent = data[14:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   // stop offering, hold until every rate word is back and the pipeline is empty
   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (rate_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic send_bin(bin_type b, bit typed, rate_type want);
      int gap;
      gap = 0;
      while ($urandom_range(99) < snd_idle && gap < 20) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         gap++;
      end
      @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.phase_slope = b.slope;
      req_bus.phase_valid = b.pv;
      req_bus.attenuated = b.att;
      req_bus.correlation = b.corr;
      req_bus.reflect_rate = b.zr;
      typed_pending = typed;
      typed_want = want;
      do @(posedge clock); while (!req_bus.ready);
      bins_sent++;
   endtask

   // accept bins into the expectation store, check rate words
   always @(posedge clock) begin
      rate_type got;
      rate_type want;
      if (!reset && req_bus.valid && req_bus.ready) begin
         want = choose_rate('{req_bus.phase_slope, req_bus.phase_valid, req_bus.attenuated,
                              req_bus.correlation, req_bus.reflect_rate});
         rate_q.push_back(typed_pending ? typed_want : want);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.rain_rate, rsp_bus.used_phase};
         if (got.used) kdp_words++;
         else fallback_words++;
         if (rate_q.size() == 0) begin
            $error("rate word with nothing expected: rain_rate %0d used_phase %0d",
                   got.rate, got.used);
            errors++;
         end else begin
            want = rate_q.pop_front();
            if (got.rate !== want.rate) begin
               $error("rain_rate: expected %0d, actual %0d", want.rate, got.rate);
               errors++;
            end
            if (got.used !== want.used) begin
               $error("used_phase: expected %0d, actual %0d", want.used, got.used);
               errors++;
            end
         end
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= rcv_idle);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycles, rate_q.size());
         $display("[kdp_rain_rate] ERROR");
         $finish;
      end
   end

   initial begin
      logic [63:0] t;
      rate_type    none;
      int          phase;
      none = '{16'd0, 1'b0};
      req_bus.valid = 1'b0;
      req_bus.phase_slope = '0;
      req_bus.phase_valid = 1'b0;
      req_bus.attenuated = 1'b0;
      req_bus.correlation = '0;
      req_bus.reflect_rate = '0;
      t = 64'd1 << 31;
      for (int j = 1; j <= 16; j++) begin
         t = floor_root(t << 30);
         exp_root[j] = t;
      end
      regs.corr_threshold = kdp_pkg::CORR_THRESHOLD_RESET;
      regs.min_usage_rate = kdp_pkg::MIN_USAGE_RATE_RESET;
      regs.rate_multiplier = kdp_pkg::RATE_MULTIPLIER_RESET;
      regs.rate_exponent = kdp_pkg::RATE_EXPONENT_RESET;

      // register defaults
      dir_rows.push_back(bin_row(100, 0, 0, 16384, 500, 1, 500, 0));
      dir_rows.push_back(bin_row(100, 1, 0, 14745, 500, 1, 500, 0));
      dir_rows.push_back(bin_row(100, 1, 0, 16384, 159, 1, 159, 0));
      dir_rows.push_back(bin_row(-256, 1, 0, 16384, 500, 1, 500, 0));
      dir_rows.push_back(bin_row(-32768, 1, 1, 16384, 65535, 1, 65535, 0));
      dir_rows.push_back(bin_row(0, 1, 1, 0, 0, 1, 0, 1));
      dir_rows.push_back(bin_row(256, 1, 0, 14746, 160, 0, 0, 0));
      dir_rows.push_back(bin_row(32767, 1, 1, 0, 0, 0, 0, 0));
      dir_rows.push_back(bin_row(1, 1, 0, 32767, 65535, 0, 0, 0));
      dir_rows.push_back(bin_row(-1, 0, 1, 32767, 65535, 1, 65535, 0));
      // zero exponent: zero phase gives the multiplier over 16
      dir_rows.push_back(csr_row(kdp_pkg::CSR_RATE_EXPONENT, 0));
      dir_rows.push_back(bin_row(0, 1, 1, 0, 0, 1, 704, 1));
      dir_rows.push_back(bin_row(1000, 1, 1, 0, 0, 0, 0, 0));
      // zero multiplier: negative phase yields zero
      dir_rows.push_back(csr_row(kdp_pkg::CSR_RATE_MULTIPLIER, 0));
      dir_rows.push_back(bin_row(-32768, 1, 1, 0, 0, 1, 0, 1));
      dir_rows.push_back(bin_row(500, 1, 1, 0, 0, 0, 0, 0));
      // top values, high data bit dropped on the 15 bit registers
      dir_rows.push_back(csr_row(kdp_pkg::CSR_RATE_MULTIPLIER, 16'hFFFF));
      dir_rows.push_back(csr_row(kdp_pkg::CSR_RATE_EXPONENT, 16'hFFFF));
      dir_rows.push_back(csr_row(kdp_pkg::CSR_CORR_THRESHOLD, 16'hFFFF));
      dir_rows.push_back(csr_row(kdp_pkg::CSR_MIN_USAGE_RATE, 0));
      dir_rows.push_back(bin_row(32767, 1, 0, 32767, 0, 0, 0, 0));
      dir_rows.push_back(bin_row(1, 1, 0, 32766, 7, 1, 7, 0));
      dir_rows.push_back(csr_row(kdp_pkg::CSR_CORR_THRESHOLD, 0));
      dir_rows.push_back(csr_row(kdp_pkg::CSR_MIN_USAGE_RATE, 16'hFFFF));
      dir_rows.push_back(bin_row(300, 1, 0, 0, 65535, 0, 0, 0));
      dir_rows.push_back(bin_row(300, 1, 0, 0, 65534, 1, 65534, 0));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            drain();
            write_reg(dir_rows[i].idx, dir_rows[i].data);
         end else begin
            send_bin(dir_rows[i].bin, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      for (phase = 0; phase < 7; phase++) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         drain();
         case (phase)
            0: begin
               write_reg(kdp_pkg::CSR_CORR_THRESHOLD, kdp_pkg::CORR_THRESHOLD_RESET);
               write_reg(kdp_pkg::CSR_MIN_USAGE_RATE, kdp_pkg::MIN_USAGE_RATE_RESET);
               write_reg(kdp_pkg::CSR_RATE_MULTIPLIER, kdp_pkg::RATE_MULTIPLIER_RESET);
               write_reg(kdp_pkg::CSR_RATE_EXPONENT, kdp_pkg::RATE_EXPONENT_RESET);
            end
            1: begin
               write_reg(kdp_pkg::CSR_CORR_THRESHOLD, 0);
               write_reg(kdp_pkg::CSR_MIN_USAGE_RATE, 0);
               write_reg(kdp_pkg::CSR_RATE_MULTIPLIER, 0);
               write_reg(kdp_pkg::CSR_RATE_EXPONENT, 0);
            end
            2: begin
               write_reg(kdp_pkg::CSR_CORR_THRESHOLD, 16'h7FFF);
               write_reg(kdp_pkg::CSR_MIN_USAGE_RATE, 16'hFFFF);
               write_reg(kdp_pkg::CSR_RATE_MULTIPLIER, 16'hFFFF);
               write_reg(kdp_pkg::CSR_RATE_EXPONENT, 16'h7FFF);
            end
            default: begin
               write_reg(kdp_pkg::CSR_CORR_THRESHOLD, 16'($urandom));
               write_reg(kdp_pkg::CSR_MIN_USAGE_RATE, 16'($urandom_range(2000)));
               write_reg(kdp_pkg::CSR_RATE_MULTIPLIER, 16'($urandom));
               write_reg(kdp_pkg::CSR_RATE_EXPONENT, 16'($urandom));
            end
         endcase
         if (phase < 3) begin
            snd_idle = 28;
            rcv_idle = 48;
         end else if (phase < 5) begin
            snd_idle = 48;
            rcv_idle = 28;
         end else begin
            snd_idle = 0;
            rcv_idle = 0;
         end
         for (int n = 0; n < PHASE_BINS; n++) begin
            // long receiver hold-off while bins keep coming: fill the pipeline
            if (n == 60 && (phase == 0 || phase == 5)) hold_left = 300;
            send_bin(random_bin(), 0, none);
         end
      end

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (rate_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("sent %0d bins over 7 register settings and 3 idle patterns,", bins_sent);
      $display("%0d Kdp rates, %0d fallbacks, %0d register writes",
               kdp_words, fallback_words, csr_writes);
      if (errors == 0) begin
         $display("[kdp_rain_rate] OK");
      end else begin
         $display("[kdp_rain_rate] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
